// ----- rtl/cgtd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgtd_pkg
// Shared types and codes for the codon Gray triangle decoder.
// ----------------------------------------------------------------------------
package cgtd_pkg;

    localparam int VAL_W = 16;   // Q3.12 value width
    localparam int SH_W  = 19;   // scaled offset before adding the low bound

    // codon classes
    localparam logic [2:0] KIND_IGNORE = 3'd0;
    localparam logic [2:0] KIND_M0     = 3'd1;
    localparam logic [2:0] KIND_M1     = 3'd2;
    localparam logic [2:0] KIND_W0     = 3'd3;
    localparam logic [2:0] KIND_W1     = 3'd4;
    localparam logic [2:0] KIND_H0     = 3'd5;
    localparam logic [2:0] KIND_H1     = 3'd6;
    localparam logic [2:0] KIND_START  = 3'd7;

    // register indexes
    localparam logic [2:0] REG_MEAN_LOW    = 3'd0;
    localparam logic [2:0] REG_MEAN_HIGH   = 3'd1;
    localparam logic [2:0] REG_WIDTH_LOW   = 3'd2;
    localparam logic [2:0] REG_WIDTH_HIGH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_LOW  = 3'd4;
    localparam logic [2:0] REG_HEIGHT_HIGH = 3'd5;

    // per-kind slots (also the gray bit positions)
    localparam logic [1:0] SLOT_MEAN   = 2'd0;
    localparam logic [1:0] SLOT_WIDTH  = 2'd1;
    localparam logic [1:0] SLOT_HEIGHT = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage
`default_nettype wire

// ----- rtl/cgtd_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgtd_divider
// Restoring divider, one quotient bit per cycle: acc / (2^n - 1) in Q1.F.
// ----------------------------------------------------------------------------
module cgtd_divider #(
    parameter int ACC_BITS  = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ACC_BITS-1:0]          i_acc,
    input  wire logic [$clog2(ACC_BITS+1)-1:0] i_nbits,
    output logic      [FRAC_BITS:0]           o_frac,
    output cgtd_pkg::t_unit_stat              o_stat
);
    import cgtd_pkg::*;

    localparam int NB_W   = $clog2(ACC_BITS + 1);
    localparam int STEP_W = $clog2(FRAC_BITS + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_sat,  n_sat;
    logic [ACC_BITS-1:0] r_div,  n_div;
    logic [ACC_BITS-1:0] r_rem,  n_rem;
    logic [FRAC_BITS:0]  r_q,    n_q;

    logic [ACC_BITS-1:0] mask;
    logic [ACC_BITS:0]   shifted;
    logic                qbit;
    logic [FRAC_BITS+1:0] rounded;

    // divisor 2^n - 1 as a mask of n low ones
    always_comb begin
        for (int i = 0; i < ACC_BITS; i++) begin
            mask[i] = (NB_W'(i) < i_nbits);
        end
    end

    assign shifted = {r_rem, 1'b0};
    assign qbit    = (shifted >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_sat  = r_sat;
        n_div  = r_div;
        n_rem  = r_rem;
        n_q    = r_q;
        if (i_start) begin
            n_div  = mask;
            n_rem  = i_acc;
            n_q    = '0;
            n_step = '0;
            n_sat  = (i_acc >= mask);
            if (i_acc >= mask) begin
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem  = qbit ? ACC_BITS'(shifted - {1'b0, r_div}) : ACC_BITS'(shifted);
            n_q    = {r_q[FRAC_BITS-1:0], qbit};
            n_step = r_step + 1'b1;
            if (r_step == STEP_W'(FRAC_BITS)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat <= n_sat;
        r_div <= n_div;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

    // round half up: drop the extra quotient bit
    assign rounded = {1'b0, r_q} + 1'b1;
    assign o_frac  = r_sat ? ((FRAC_BITS+1)'(1) << FRAC_BITS) : rounded[FRAC_BITS+1:1];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

// ----- rtl/cgtd_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cgtd_scale
// Affine map of a Q1.F fraction into [low, high], Q3.12, saturated. 4 stages.
// ----------------------------------------------------------------------------
module cgtd_scale #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [cgtd_pkg::VAL_W-1:0]  i_lo,
    input  wire logic signed [cgtd_pkg::VAL_W-1:0]  i_hi,
    input  wire logic        [FRAC_BITS:0]          i_frac,
    output logic signed      [cgtd_pkg::VAL_W-1:0]  o_value,
    output cgtd_pkg::t_unit_stat                    o_stat
);
    import cgtd_pkg::*;

    localparam int PROD_W = FRAC_BITS + VAL_W + 3;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

    logic [3:0]                r_stage, n_stage;
    logic signed [VAL_W-1:0]   r_lo;
    logic signed [VAL_W:0]     r_span;
    logic        [FRAC_BITS:0] r_frac;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [SH_W-1:0]    r_sh;
    logic signed [VAL_W-1:0]   r_value;

    logic signed [PROD_W-1:0]  span_x;
    logic signed [PROD_W-1:0]  frac_x;
    logic [PROD_W-1:0]         sum;
    logic signed [SH_W:0]      total;

    // operands widened to the product width: span signed, fraction unsigned
    assign span_x  = {{(PROD_W-VAL_W-1){r_span[VAL_W]}}, r_span};
    assign frac_x  = {{(PROD_W-FRAC_BITS-1){1'b0}}, r_frac};
    assign n_stage = {r_stage[2:0], i_start};
    assign sum     = r_prod + HALF;
    assign total   = {{(SH_W+1-VAL_W){r_lo[VAL_W-1]}}, r_lo} + {r_sh[SH_W-1], r_sh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= n_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo   <= i_lo;
            r_span <= {i_hi[VAL_W-1], i_hi} - {i_lo[VAL_W-1], i_lo};
            r_frac <= i_frac;
        end
        if (r_stage[0]) begin
            r_prod <= span_x * frac_x;
        end
        if (r_stage[1]) begin
            // slice of a signed word: floor shift
            r_sh <= sum[PROD_W-1:FRAC_BITS];
        end
        if (r_stage[2]) begin
            if (total > (SH_W+1)'(32767)) begin
                r_value <= 16'sh7fff;
            end else if (total < -(SH_W+1)'(32768)) begin
                r_value <= 16'sh8000;
            end else begin
                r_value <= total[VAL_W-1:0];
            end
        end
    end

    assign o_value     = r_value;
    assign o_stat.busy = |r_stage[2:0];
    assign o_stat.done = r_stage[3];

endmodule
`default_nettype wire

// ----- rtl/codon_gray_triangle_decoder.sv -----
`default_nettype none
// A codon without the last flag is absorbed while the input is not stalled, one per cycle.
// After a last codon's transfer, output valid rises once each kind has passed through
// a start state, FRAC_BITS+1 divider steps, a done strobe, 4 scaler stages and
// a handoff; a full-scale or empty kind skips the divider steps. Throughput: 1 codon/cycle
// between results; input stalls for the final math and while the previous result waits.
// Reset (synchronous, i_rst_n low): protein state cleared, registers to defaults, valid low.
// ----------------------------------------------------------------------------
// codon_gray_triangle_decoder
// Gray-decodes mean/width/height codon runs and maps them to triangle values.
// ----------------------------------------------------------------------------
module codon_gray_triangle_decoder #(
    parameter int ACC_BITS   = 32,
    parameter int FRAC_BITS  = 16,
    parameter int MAX_CODONS = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [2:0]                        i_cfg_idx,
    input  wire logic [cgtd_pkg::VAL_W-1:0]        i_cfg_data,
    // codon input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [2:0]                        i_codon_kind,
    input  wire logic                              i_last_codon,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [cgtd_pkg::VAL_W-1:0]      o_mean_value,
    output logic signed [cgtd_pkg::VAL_W-1:0]      o_width_value,
    output logic signed [cgtd_pkg::VAL_W-1:0]      o_height_value,
    output logic                                   o_functional
);
    import cgtd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CODONS + 1);
    localparam int NB_W  = $clog2(ACC_BITS + 1);
    localparam logic [FRAC_BITS:0] FRAC_HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SCL_WAIT,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_sel, n_sel;

    // configuration registers
    logic signed [VAL_W-1:0] r_mean_low, r_mean_high;
    logic signed [VAL_W-1:0] r_width_low, r_width_high;
    logic signed [VAL_W-1:0] r_height_low, r_height_high;

    // per-kind protein state, slot = gray bit position
    logic [ACC_BITS-1:0] r_acc [3];
    logic [ACC_BITS-1:0] n_acc [3];
    logic [CNT_W-1:0]    r_cnt [3];
    logic [CNT_W-1:0]    n_cnt [3];
    logic [2:0]          r_gray, n_gray;

    // scaled values per slot
    logic signed [VAL_W-1:0] r_val [3];

    // result register
    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_out_mean, r_out_width, r_out_height;
    logic                    r_out_func;

    logic in_xfer, out_xfer, out_load;
    logic hit;
    logic [1:0] hit_slot;
    logic coded;

    // shared units
    t_unit_stat              div_stat, scl_stat;
    logic                    div_start, scl_start;
    logic [FRAC_BITS:0]      div_frac, scl_frac;
    logic [NB_W-1:0]         sel_nbits;
    logic signed [VAL_W-1:0] scl_lo, scl_hi, scl_value;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // codon decode
    always_comb begin
        hit      = 1'b1;
        hit_slot = SLOT_MEAN;
        coded    = 1'b0;
        case (i_codon_kind)
            KIND_M0:    begin hit_slot = SLOT_MEAN;   coded = 1'b0; end
            KIND_M1:    begin hit_slot = SLOT_MEAN;   coded = 1'b1; end
            KIND_W0:    begin hit_slot = SLOT_WIDTH;  coded = 1'b0; end
            KIND_W1:    begin hit_slot = SLOT_WIDTH;  coded = 1'b1; end
            KIND_H0:    begin hit_slot = SLOT_HEIGHT; coded = 1'b0; end
            KIND_START: begin hit_slot = SLOT_HEIGHT; coded = 1'b0; end
            KIND_H1:    begin hit_slot = SLOT_HEIGHT; coded = 1'b1; end
            KIND_IGNORE: hit = 1'b0;
            default:     hit = 1'b0;
        endcase
    end

    // absorb: running xor, shift while below both limits, saturating count
    always_comb begin
        logic g;
        g      = 1'b0;
        n_gray = r_gray;
        for (int k = 0; k < 3; k++) begin
            n_acc[k] = r_acc[k];
            n_cnt[k] = r_cnt[k];
        end
        if (in_xfer && hit) begin
            for (int k = 0; k < 3; k++) begin
                if (hit_slot == 2'(k)) begin
                    g         = r_gray[k] ^ coded;
                    n_gray[k] = g;
                    if ((32'(r_cnt[k]) < ACC_BITS) && (32'(r_cnt[k]) < MAX_CODONS)) begin
                        n_acc[k] = {r_acc[k][ACC_BITS-2:0], g};
                    end
                    if (32'(r_cnt[k]) < MAX_CODONS) begin
                        n_cnt[k] = r_cnt[k] + 1'b1;
                    end
                end
            end
        end
        // result loaded into the output register: start a fresh protein
        if (out_load) begin
            n_gray = '0;
            for (int k = 0; k < 3; k++) begin
                n_acc[k] = '0;
                n_cnt[k] = '0;
            end
        end
    end

    // sequencer: three passes through divider then scaler
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_last_codon) begin
                    n_state = S_DIV_GO;
                    n_sel   = SLOT_MEAN;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_stat.done) begin
                    n_state = S_SCL_WAIT;
                end
            end
            S_SCL_WAIT: begin
                if (scl_stat.done) begin
                    if (r_sel == SLOT_HEIGHT) begin
                        n_state = S_OUT;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = out_load ? 1'b1 : (out_xfer ? 1'b0 : r_out_valid);

    // bits held = min(count, ACC_BITS)
    assign sel_nbits = (32'(r_cnt[r_sel]) < ACC_BITS) ? NB_W'(r_cnt[r_sel]) : NB_W'(ACC_BITS);
    assign div_start = (r_state == S_DIV_GO);
    assign scl_start = (r_state == S_DIV_WAIT) && div_stat.done;

    // empty kind falls back to 0.5 / 0.0 / 0.5
    always_comb begin
        scl_frac = div_frac;
        if (r_cnt[r_sel] == '0) begin
            scl_frac = (r_sel == SLOT_WIDTH) ? '0 : FRAC_HALF;
        end
    end

    always_comb begin
        case (r_sel)
            SLOT_MEAN:   begin scl_lo = r_mean_low;   scl_hi = r_mean_high;   end
            SLOT_WIDTH:  begin scl_lo = r_width_low;  scl_hi = r_width_high;  end
            SLOT_HEIGHT: begin scl_lo = r_height_low; scl_hi = r_height_high; end
            default:     begin scl_lo = r_mean_low;   scl_hi = r_mean_high;   end
        endcase
    end

    cgtd_divider #(
        .ACC_BITS  (ACC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_acc   (r_acc[r_sel]),
        .i_nbits (sel_nbits),
        .o_frac  (div_frac),
        .o_stat  (div_stat)
    );

    cgtd_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scl_start),
        .i_lo    (scl_lo),
        .i_hi    (scl_hi),
        .i_frac  (scl_frac),
        .o_value (scl_value),
        .o_stat  (scl_stat)
    );

    // state, protein, configuration, result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sel         <= SLOT_MEAN;
            r_gray        <= '0;
            r_out_valid   <= 1'b0;
            r_mean_low    <= 16'sd0;
            r_mean_high   <= 16'sd4096;
            r_width_low   <= 16'sd0;
            r_width_high  <= 16'sd137;
            r_height_low  <= -16'sd4096;
            r_height_high <= 16'sd4096;
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_gray      <= n_gray;
            r_out_valid <= n_out_valid;
            for (int k = 0; k < 3; k++) begin
                r_acc[k] <= n_acc[k];
                r_cnt[k] <= n_cnt[k];
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MEAN_LOW:    r_mean_low    <= i_cfg_data;
                    REG_MEAN_HIGH:   r_mean_high   <= i_cfg_data;
                    REG_WIDTH_LOW:   r_width_low   <= i_cfg_data;
                    REG_WIDTH_HIGH:  r_width_high  <= i_cfg_data;
                    REG_HEIGHT_LOW:  r_height_low  <= i_cfg_data;
                    REG_HEIGHT_HIGH: r_height_high <= i_cfg_data;
                    default: ;
                endcase
            end
            // payload: per-kind values, then the result transfer
            if ((r_state == S_SCL_WAIT) && scl_stat.done) begin
                r_val[r_sel] <= scl_value;
            end
            if (out_load) begin
                r_out_mean   <= r_val[SLOT_MEAN];
                r_out_width  <= r_val[SLOT_WIDTH];
                r_out_height <= r_val[SLOT_HEIGHT];
                r_out_func   <= (r_cnt[SLOT_MEAN] != '0) && (r_cnt[SLOT_WIDTH] != '0) &&
                                (r_cnt[SLOT_HEIGHT] != '0) && (r_val[SLOT_WIDTH] != '0) &&
                                (r_val[SLOT_HEIGHT] != '0);
            end
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_mean_value   = r_out_mean;
    assign o_width_value  = r_out_width;
    assign o_height_value = r_out_height;
    assign o_functional   = r_out_func;

endmodule
`default_nettype wire

// ----- test/triangle_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scoreboard
// Follows codon transfers and register writes, predicts each triangle and
// compares it field by field with the transfer the decoder delivers.
// ----------------------------------------------------------------------------
module triangle_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_idx,
    input  logic [cgtd_pkg::VAL_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic [2:0]                        i_codon_kind,
    input  logic                              i_last_codon,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [cgtd_pkg::VAL_W-1:0] i_mean_value,
    input  logic signed [cgtd_pkg::VAL_W-1:0] i_width_value,
    input  logic signed [cgtd_pkg::VAL_W-1:0] i_height_value,
    input  logic                              i_functional,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_checked
);
    import cgtd_pkg::*;

    localparam int ACC_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int COUNT_MAX = 4096;

    localparam logic [FRAC_W:0] FRAC_ONE  = 17'h10000;
    localparam logic [FRAC_W:0] FRAC_HALF = 17'h08000;
    localparam logic [FRAC_W:0] FRAC_ZERO = 17'h00000;

    typedef struct {
        logic signed [VAL_W-1:0] mean;
        logic signed [VAL_W-1:0] width;
        logic signed [VAL_W-1:0] height;
        logic                    functional;
    } t_triangle;

    t_triangle expected_triangles[$];

    // per-kind decode state, indexed by slot
    logic [ACC_W-1:0]        acc         [3];
    logic [12:0]             codon_count [3];
    logic [2:0]              gray;
    logic signed [VAL_W-1:0] range_low   [3];
    logic signed [VAL_W-1:0] range_high  [3];

    // acc / (2^n - 1) as Q1.16, rounded half up; n = bits actually held
    function automatic logic [FRAC_W:0] frac_of(logic [ACC_W-1:0] a, logic [12:0] cnt);
        int unsigned nbits;
        logic [63:0] divisor;
        logic [63:0] quo;
        nbits   = (cnt < ACC_W) ? cnt : ACC_W;
        divisor = (64'd1 << nbits) - 64'd1;
        if ({32'd0, a} >= divisor)
            return FRAC_ONE;
        quo = ({32'd0, a} << (FRAC_W + 1)) / divisor;
        return (FRAC_W + 1)'((quo + 64'd1) >> 1);
    endfunction

    function automatic logic signed [VAL_W-1:0] map_range(logic signed [VAL_W-1:0] lo,
                                                          logic signed [VAL_W-1:0] hi,
                                                          logic [FRAC_W:0] frac);
        longint span;
        longint prod;
        longint v;
        span = longint'(hi) - longint'(lo);
        prod = span * longint'(frac) + 64'sd32768;
        v    = longint'(lo) + (prod >>> FRAC_W);   // arithmetic shift floors
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return VAL_W'(v);
    endfunction

    task automatic absorb(input logic [1:0] slot, input logic coded);
        if (coded)
            gray[slot] = ~gray[slot];
        // ACC_W is below COUNT_MAX, so the width bound is the one that bites
        if (codon_count[slot] < ACC_W)
            acc[slot] = {acc[slot][ACC_W-2:0], gray[slot]};
        if (codon_count[slot] < COUNT_MAX)
            codon_count[slot] = codon_count[slot] + 13'd1;
    endtask

    task automatic clear_protein();
        for (int s = 0; s < 3; s++) begin
            acc[s]         = '0;
            codon_count[s] = '0;
        end
        gray = '0;
    endtask

    function automatic t_triangle finish_protein();
        t_triangle t;
        logic [FRAC_W:0] f_mean;
        logic [FRAC_W:0] f_width;
        logic [FRAC_W:0] f_height;
        f_mean   = (codon_count[SLOT_MEAN] != 0) ?
                   frac_of(acc[SLOT_MEAN], codon_count[SLOT_MEAN]) : FRAC_HALF;
        f_width  = (codon_count[SLOT_WIDTH] != 0) ?
                   frac_of(acc[SLOT_WIDTH], codon_count[SLOT_WIDTH]) : FRAC_ZERO;
        f_height = (codon_count[SLOT_HEIGHT] != 0) ?
                   frac_of(acc[SLOT_HEIGHT], codon_count[SLOT_HEIGHT]) : FRAC_HALF;
        t.mean   = map_range(range_low[SLOT_MEAN], range_high[SLOT_MEAN], f_mean);
        t.width  = map_range(range_low[SLOT_WIDTH], range_high[SLOT_WIDTH], f_width);
        t.height = map_range(range_low[SLOT_HEIGHT], range_high[SLOT_HEIGHT], f_height);
        t.functional = (codon_count[SLOT_MEAN] != 0) && (codon_count[SLOT_WIDTH] != 0) &&
                       (codon_count[SLOT_HEIGHT] != 0) && (t.width != 0) && (t.height != 0);
        return t;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            o_errors = o_errors + 1;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_triangle want;
        if (!i_rst_n) begin
            range_low[SLOT_MEAN]    = 16'sd0;
            range_high[SLOT_MEAN]   = 16'sd4096;
            range_low[SLOT_WIDTH]   = 16'sd0;
            range_high[SLOT_WIDTH]  = 16'sd137;
            range_low[SLOT_HEIGHT]  = -16'sd4096;
            range_high[SLOT_HEIGHT] = 16'sd4096;
            clear_protein();
            expected_triangles.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_triangles.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d/%0d",
                             $time, i_mean_value, i_width_value, i_height_value,
                             i_functional);
                end else begin
                    want = expected_triangles.pop_front();
                    compare_field("mean", int'(want.mean), int'(i_mean_value));
                    compare_field("width", int'(want.width), int'(i_width_value));
                    compare_field("height", int'(want.height), int'(i_height_value));
                    compare_field("functional", int'(want.functional), int'(i_functional));
                    o_checked = o_checked + 1;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MEAN_LOW:    range_low[SLOT_MEAN]    = i_cfg_data;
                    REG_MEAN_HIGH:   range_high[SLOT_MEAN]   = i_cfg_data;
                    REG_WIDTH_LOW:   range_low[SLOT_WIDTH]   = i_cfg_data;
                    REG_WIDTH_HIGH:  range_high[SLOT_WIDTH]  = i_cfg_data;
                    REG_HEIGHT_LOW:  range_low[SLOT_HEIGHT]  = i_cfg_data;
                    REG_HEIGHT_HIGH: range_high[SLOT_HEIGHT] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_codon_kind)
                    KIND_M0:               absorb(SLOT_MEAN, 1'b0);
                    KIND_M1:               absorb(SLOT_MEAN, 1'b1);
                    KIND_W0:               absorb(SLOT_WIDTH, 1'b0);
                    KIND_W1:               absorb(SLOT_WIDTH, 1'b1);
                    KIND_H0, KIND_START:   absorb(SLOT_HEIGHT, 1'b0);
                    KIND_H1:               absorb(SLOT_HEIGHT, 1'b1);
                    default: ;
                endcase
                if (i_last_codon) begin
                    expected_triangles.push_back(finish_protein());
                    clear_protein();
                end
            end
        end
        o_pending = expected_triangles.size();
    end

endmodule

// ----- test/tb_codon_gray_triangle_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_codon_gray_triangle_decoder
// Drives codon streams and range settings into the decoder with random idle
// and stall patterns; a separate scoreboard predicts and checks each triangle.
// ----------------------------------------------------------------------------
module tb_codon_gray_triangle_decoder;
    import cgtd_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 150;     // well past the final math
    localparam int HOLD_CYCLES   = 400;     // long result hold for back-pressure
    localparam int RANDOM_CODONS = 1500;
    localparam int PHASE_CODONS  = 150;
    localparam int SAT_RUN       = 64;      // twice the accumulator width

    localparam logic signed [VAL_W-1:0] Q_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] Q_MAX = 16'sh7FFF;

    // register indexes past the last real one; writes there must do nothing
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic [2:0]       cfg_idx    = REG_MEAN_LOW;
    logic [VAL_W-1:0] cfg_data   = '0;
    logic             in_valid   = 1'b0;
    logic [2:0]       codon_kind = KIND_IGNORE;
    logic             last_codon = 1'b0;
    logic             out_stall  = 1'b0;

    logic                    in_stall;
    logic                    out_valid;
    logic signed [VAL_W-1:0] mean_value;
    logic signed [VAL_W-1:0] width_value;
    logic signed [VAL_W-1:0] height_value;
    logic                    functional;

    int errors;
    int pending;
    int checked;

    int cycles       = 0;
    int codons_sent  = 0;   // non-ignored codons transferred
    int ignored_sent = 0;
    int range_sets   = 0;

    // flags shared between the stimulus and the result sink
    bit send_rush     = 1'b0;   // no idle gaps on the codon side
    bit recv_rush     = 1'b0;   // no stalls on the result side
    bit long_hold_req = 1'b0;   // ask the sink for one long hold

    codon_gray_triangle_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_codon_kind   (codon_kind),
        .i_last_codon   (last_codon),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_mean_value   (mean_value),
        .o_width_value  (width_value),
        .o_height_value (height_value),
        .o_functional   (functional)
    );

    triangle_scoreboard u_triangle_scoreboard (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_codon_kind   (codon_kind),
        .i_last_codon   (last_codon),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_mean_value   (mean_value),
        .i_width_value  (width_value),
        .i_height_value (height_value),
        .i_functional   (functional),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Codon side. Every task starts and ends just after a rising edge.
    // Stall is sampled at the falling edge: inputs only move at rising edges,
    // so that value is the one the next rising edge acts on.
    // ------------------------------------------------------------------------
    task automatic send_codon(input logic [2:0] kind, input logic last);
        int gap;
        bit taken;
        gap = send_rush ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // with no gap valid simply stays high; only the payload moves
        in_valid   <= 1'b1;
        codon_kind <= kind;
        last_codon <= last;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        if (kind == KIND_IGNORE)
            ignored_sent++;
        else
            codons_sent++;
    endtask

    // one codon of a family: 0 mean, 1 width, 2 height (start stands in for h0)
    function automatic logic [2:0] family_codon(input int fam, input bit one);
        case (fam)
            0:       return one ? KIND_M1 : KIND_M0;
            1:       return one ? KIND_W1 : KIND_W0;
            default: return one ? KIND_H1 :
                            (($urandom_range(0, 3) == 0) ? KIND_START : KIND_H0);
        endcase
    endfunction

    // Random protein. Mostly well-formed mixes; one in ten is a long run, mostly of
    // a single family, longer than the accumulator width, one in ten is raw noise that
    // may miss whole families or end on an ignored codon.
    task automatic send_protein(input int max_len);
        int style;
        int len;
        int fam;
        int k;
        logic [2:0] kind;
        style = $urandom_range(0, 9);
        fam   = $urandom_range(0, 2);
        len   = (style == 0) ? $urandom_range(33, 70) : $urandom_range(1, max_len);
        for (k = 0; k < len; k++) begin
            if (style == 0)
                kind = ($urandom_range(0, 7) == 0) ?
                       family_codon($urandom_range(0, 2), $urandom_range(0, 1)) :
                       family_codon(fam, $urandom_range(0, 1));
            else if (style == 1)
                kind = 3'($urandom_range(0, 7));
            else if ($urandom_range(0, 15) == 0)
                kind = KIND_IGNORE;
            else
                kind = family_codon($urandom_range(0, 2), $urandom_range(0, 1));
            send_codon(kind, k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Register writes: one per cycle, enable dropped after the last one.
    // ------------------------------------------------------------------------
    task automatic put_reg(input logic [2:0] idx, input logic [VAL_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic load_ranges(input logic signed [VAL_W-1:0] ml, mh, wl, wh, hl, hh);
        put_reg(REG_MEAN_LOW, ml);
        put_reg(REG_MEAN_HIGH, mh);
        put_reg(REG_WIDTH_LOW, wl);
        put_reg(REG_WIDTH_HIGH, wh);
        put_reg(REG_HEIGHT_LOW, hl);
        put_reg(REG_HEIGHT_HIGH, hh);
        // a stray write to an unused index must leave every range alone
        put_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        cfg_we <= 1'b0;
        range_sets++;
    endtask

    // Idle point: stop offering codons, wait until all predicted results are
    // delivered, then leave a quiet stretch before anything else moves.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: a random stall before each transfer, plus one long hold on
    // request so the decoder backs up and stalls its codon input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        bit got;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = recv_rush ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                got = out_valid;
                @(posedge clk);
            end while (!got);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int ph;
        int target;
        int phase_end;
        int k;
        logic signed [VAL_W-1:0] wl;
        logic signed [VAL_W-1:0] hl;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed proteins under the reset ranges.
        // Empty protein: an ignored codon alone still ends it; all defaults.
        send_codon(KIND_IGNORE, 1'b1);
        // every codon class once, ending on a start codon
        send_codon(KIND_M0, 1'b0);
        send_codon(KIND_M1, 1'b0);
        send_codon(KIND_W0, 1'b0);
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_H0, 1'b0);
        send_codon(KIND_H1, 1'b0);
        send_codon(KIND_START, 1'b1);
        // lone mean bit; lone start counted as height
        send_codon(KIND_M1, 1'b1);
        send_codon(KIND_START, 1'b1);
        // Gray toggling within one family, closed by an ignored codon
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_IGNORE, 1'b1);
        // all-ones width and height accumulators hit a full-scale fraction
        send_codon(KIND_M1, 1'b0);
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_H1, 1'b0);
        send_codon(KIND_M1, 1'b0);
        send_codon(KIND_H0, 1'b1);

        // A full-scale protein against the widest and the inverted range.
        wait_drained();
        load_ranges(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_codon(KIND_M1, 1'b0);
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_H1, 1'b1);
        wait_drained();
        load_ranges(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_codon(KIND_M1, 1'b0);
        send_codon(KIND_W1, 1'b0);
        send_codon(KIND_H1, 1'b1);

        // Random phases, each under its own range setting. Every fourth phase
        // runs with no idling on either side.
        target = codons_sent + RANDOM_CODONS;
        for (ph = 0; codons_sent < target; ph++) begin
            wait_drained();
            case (ph % 5)
                0: load_ranges(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
                1: load_ranges(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
                2: load_ranges(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom));
                3: begin
                    // collapsed ranges: width (and sometimes height) pinned
                    wl = ($urandom_range(0, 1) != 0) ? 16'sd0 : 16'($urandom);
                    hl = ($urandom_range(0, 1) != 0) ? 16'sd0 : 16'($urandom);
                    load_ranges(16'($urandom), 16'($urandom), wl, wl, hl,
                                ($urandom_range(0, 1) != 0) ? hl : 16'($urandom));
                end
                default: load_ranges(16'($urandom_range(0, 400)) - 16'sd200,
                                     16'($urandom_range(0, 400)) - 16'sd200,
                                     16'($urandom_range(0, 400)) - 16'sd200,
                                     16'($urandom_range(0, 400)) - 16'sd200,
                                     16'($urandom_range(0, 400)) - 16'sd200,
                                     16'($urandom_range(0, 400)) - 16'sd200);
            endcase
            send_rush = (ph % 4 == 3);
            recv_rush = send_rush;
            phase_end = codons_sent + PHASE_CODONS;
            while (codons_sent < phase_end)
                send_protein(30);
        end

        // Back-pressure: the sink holds for a long stretch while codons keep
        // coming with no gaps, so the decoder fills and stalls its input.
        wait_drained();
        send_rush     = 1'b1;
        recv_rush     = 1'b0;
        long_hold_req = 1'b1;
        repeat (8) send_protein(6);

        // Long width run: well past the accumulator width, so only the first
        // bits up to that width stay and the divisor sits at its limit.
        recv_rush = 1'b1;
        send_codon(KIND_M1, 1'b0);
        for (k = 0; k < SAT_RUN; k++)
            send_codon(family_codon(1, $urandom_range(0, 1)), 1'b0);
        send_codon(KIND_H1, 1'b1);

        wait_drained();
        $display("Covered %0d codons plus %0d ignored, %0d triangles checked, %0d range sets",
                 codons_sent, ignored_sent, checked, range_sets);
        $display("Included long single-family runs, a %0d-codon width run and a %0d-cycle hold",
                 SAT_RUN, HOLD_CYCLES);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
